// ----- src/half_float_multiply_top_macros.svh -----
// Assertion macros for the binary16 multiplier.
// Included by RTL files that carry concurrent checks.
`ifndef HALF_FLOAT_MULTIPLY_TOP_MACROS_SVH
`define HALF_FLOAT_MULTIPLY_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define HFM_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("hfm check");
`define HFM_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) else $error("hfm check");
`else
`define HFM_ASSERT(label, clk, rst_n, prop)
`define HFM_ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

// ----- src/hfm_pkg.sv -----
// Types and constants for the binary16 multiplier.
// No dependencies.
`default_nettype none
package hfm_pkg;
  typedef enum logic [1:0] {
    RM_ZERO = 2'd0,
    RM_NEAR = 2'd1,
    RM_PINF = 2'd2,
    RM_NINF = 2'd3
  } rmode_t;
  localparam logic [15:0] QNAN_BITS   = 16'h7E00;
  localparam logic [14:0] INF_BITS    = 15'h7C00;
  localparam logic [14:0] MAXFIN_BITS = 15'h7BFF;
  localparam logic [4:0]  EXP_MAX     = 5'd31;
  localparam int          FRAC_BITS   = 10;
endpackage
`default_nettype wire

// ----- src/hfm_core.sv -----
// Combinational binary16 product: decode, multiply, align, round, pack.
// Depends on hfm_pkg.
`default_nettype none
module hfm_core (
  input  wire logic [15:0]     a,
  input  wire logic [15:0]     b,
  input  wire hfm_pkg::rmode_t mode,
  output logic [15:0]          y
);
  import hfm_pkg::*;

  logic        sa, sb, sign;
  logic [4:0]  xa, xb;
  logic [9:0]  fa, fb;
  logic        nan_a, nan_b, inf_a, inf_b, zero_a, zero_b;
  logic [10:0] ma, mb;
  logic [21:0] p;
  logic [4:0]  n;
  logic signed [7:0] ea, eb, e, eres, r;
  logic [21:0] q;
  logic [5:0]  rs;
  logic        guard, sticky, inc;
  logic [16:0] bits;
  logic [14:0] ovf;

  always_comb begin
    sa = a[15]; sb = b[15]; sign = sa ^ sb;
    xa = a[14:10]; xb = b[14:10]; fa = a[9:0]; fb = b[9:0];
    nan_a = (xa == EXP_MAX) && (fa != '0);
    nan_b = (xb == EXP_MAX) && (fb != '0);
    inf_a = (xa == EXP_MAX) && (fa == '0);
    inf_b = (xb == EXP_MAX) && (fb == '0);
    zero_a = (xa == '0) && (fa == '0);
    zero_b = (xb == '0) && (fb == '0);
    ma = {(xa != '0), fa};
    mb = {(xb != '0), fb};
    ea = (xa != '0) ? {3'b0, xa} : 8'sd1;
    eb = (xb != '0) ? {3'b0, xb} : 8'sd1;
    p = 22'(ma * mb);
    n = '0;
    for (int i = 0; i < 22; i++) begin
      if (p[i]) n = 5'(i);
    end
    e = $signed({3'b0, n}) + ea + eb - 8'sd35;
    eres = (e < 8'sd1) ? 8'sd1 : e;
    r = eres + 8'sd25 - ea - eb;
    guard = 1'b0; sticky = 1'b0;
    rs = '0;
    if (r <= 8'sd0) begin
      q = p << 5'(-r);
    end else if (r >= 8'sd23) begin
      q = '0;
      sticky = 1'b1;
    end else begin
      rs = 6'(r);
      q = p >> rs;
      guard = p[5'(rs - 6'd1)];
      sticky = (p & ((22'd1 << (rs - 6'd1)) - 22'd1)) != '0;
    end
    unique case (mode)
      RM_ZERO: inc = 1'b0;
      RM_NEAR: inc = guard && (sticky || q[0]);
      RM_PINF: inc = (guard || sticky) && !sign;
      RM_NINF: inc = (guard || sticky) && sign;
      default: inc = 1'b0;
    endcase
    bits = {1'b0, 6'(eres - 8'sd1), 10'b0} + {1'b0, q[15:0]} + 17'(inc);
    unique case (mode)
      RM_ZERO: ovf = MAXFIN_BITS;
      RM_NEAR: ovf = INF_BITS;
      RM_PINF: ovf = sign ? MAXFIN_BITS : INF_BITS;
      RM_NINF: ovf = sign ? INF_BITS : MAXFIN_BITS;
      default: ovf = INF_BITS;
    endcase
    priority if (nan_a || nan_b) y = QNAN_BITS;
    else if ((inf_a && zero_b) || (zero_a && inf_b)) y = QNAN_BITS;
    else if (zero_a || zero_b) y = {sign, 15'b0};
    else if (inf_a || inf_b) y = {sign, INF_BITS};
    else if (bits >= 17'(INF_BITS)) y = {sign, ovf};
    else y = {sign, bits[14:0]};
  end
endmodule
`default_nettype wire

// ----- src/half_float_multiply_top.sv -----
// Top level of the binary16 multiplier: input register, core, output register.
// Depends on hfm_pkg, hfm_core and the assertion macro header.
//
//  channel | ports          | payload
//  in      | in_t*          | tdata[15:0] operand_a, [31:16] operand_b
//  out     | out_t*         | tdata[15:0] product
//  cfg     | cfg_we/cfg_wdata | round_mode
// Each beat passes through d1_r and then d2_r from acceptance to output; one beat per cycle while out is not stalled.
// Throughput is set by the single core between the two register stages.
// Reset clears valids and sets round_mode to nearest even.
// A stall on out holds both stages; a free stage takes a beat at once.
`default_nettype none
`include "half_float_multiply_top_macros.svh"
module half_float_multiply_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_wdata,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // operand_a, operand_b
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata   // product
);
  import hfm_pkg::*;

  rmode_t      mode_r;
  logic        v1_r, v2_r;
  logic [31:0] d1_r;
  logic [15:0] d2_r, y;
  logic        adv2, adv1;

  hfm_core u_core (.a(d1_r[15:0]), .b(d1_r[31:16]), .mode(mode_r), .y(y));

  assign adv2 = !v2_r || out_tready;
  assign adv1 = !v1_r || adv2;
  assign in_tready = adv1;
  assign out_tvalid = v2_r;
  assign out_tdata = d2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= RM_NEAR;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      if (cfg_we) mode_r <= rmode_t'(cfg_wdata);
      if (adv2) v2_r <= v1_r;
      if (adv1) v1_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv2 && v1_r) d2_r <= y;
    if (adv1 && in_tvalid) d1_r <= in_tdata;
  end

  `HFM_ASSERT(a_hold, clk, rst_n, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
  `HFM_ASSERT(a_ready, clk, rst_n, !v1_r |-> in_tready)
  `HFM_ASSERT(a_move, clk, rst_n, v1_r && adv2 |=> v2_r)
  `HFM_ASSERT_ALWAYS(a_rst, clk, !rst_n |=> !out_tvalid)
endmodule
`default_nettype wire
